@@ hdl/ctip_pkg.sv @@
// Shared types and constants for the cassette tape image parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ctip_pkg;
    localparam int LINE_LIMIT_DEF = 1024;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_A     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_B     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYS_MARK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_MARK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_MARK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASIC_MARK = 3'd5;

    localparam logic [7:0] RST_SYNC_A     = 8'hA5;
    localparam logic [7:0] RST_SYNC_B     = 8'h66;
    localparam logic [7:0] RST_SYS_MARK   = 8'h55;
    localparam logic [7:0] RST_DATA_MARK  = 8'h3C;
    localparam logic [7:0] RST_ENTRY_MARK = 8'h78;
    localparam logic [7:0] RST_BASIC_MARK = 8'hD3;

    localparam logic [3:0] REPLAY_NONE  = 4'd8;
    localparam logic [3:0] REPLAY_BAS1  = 4'd4;
    localparam logic [3:0] REPLAY_BAS2  = 4'd1;
    localparam logic [8:0] FULL_BLOCK   = 9'd256;

    typedef enum logic [4:0] {
        PH_SILENCE, PH_WAIT_SYNC, PH_HEADER,
        PH_SYS_TYPE, PH_SYS_COUNT, PH_SYS_ALO, PH_SYS_AHI, PH_SYS_DATA, PH_SYS_SUM,
        PH_SYS_ELO, PH_SYS_EHI, PH_AFTER_ENTRY,
        PH_BAS_ALO, PH_BAS_AHI, PH_BAS_LLO, PH_BAS_LHI, PH_BAS_DATA, PH_IGNORE
    } t_phase;

    typedef enum logic [3:0] {
        EV_SYS_HDR, EV_BAS1_HDR, EV_BAS2_HDR, EV_BLK_START, EV_DATA, EV_CSUM,
        EV_ENTRY, EV_LINE_START, EV_LINE_BYTE, EV_LINE_END, EV_PROG_END,
        EV_IGNORED, EV_UNEXPECTED
    } t_event;

    typedef enum logic [1:0] {
        C_IDLE, C_FEED, C_FIN
    } t_ctl_state;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [15:0] address;
        logic [15:0] line_number;
        logic [7:0]  byte_value;
        logic [7:0]  computed_sum;
        logic [10:0] block_length;
        logic [47:0] name_text;
        logic        checksum_ok;
        logic        machine_kind;
    } t_res;

    typedef struct packed {
        logic load;
        logic feed;
        logic fin;
    } t_ctl_cmd;

    typedef struct packed {
        logic res;
        logic pend;
        logic ofree;
        logic more;
    } t_ctl_sts;
endpackage
`default_nettype wire

@@ hdl/ctip_in_if.sv @@
// Input channel: one tape byte per beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface ctip_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] tape_byte;
    logic       new_image;
    modport source (output valid, output tape_byte, output new_image, input ready);
    modport sink (input valid, input tape_byte, input new_image, output ready);
endinterface
`default_nettype wire

@@ hdl/ctip_out_if.sv @@
// Output channel: one parse event per beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface ctip_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_res;
    logic [15:0] address;
    logic [15:0] line_number;
    logic [7:0]  byte_value;
    logic [7:0]  computed_sum;
    logic [10:0] block_length;
    logic [47:0] name_text;
    logic        checksum_ok;
    logic        machine_kind;
    logic        last;
    modport source (output valid, output event_res, output address, output line_number,
                    output byte_value, output computed_sum, output block_length,
                    output name_text, output checksum_ok, output machine_kind,
                    output last, input ready);
    modport sink (input valid, input event_res, input address, input line_number,
                  input byte_value, input computed_sum, input block_length,
                  input name_text, input checksum_ok, input machine_kind,
                  input last, output ready);
endinterface
`default_nettype wire

@@ hdl/ctip_ctrl.sv @@
// Sequencer: accept a beat, feed it and the replayed header bytes, flush the last event.
// Depends on ctip_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ctip_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  ctip_pkg::t_ctl_sts i_sts,
    output ctip_pkg::t_ctl_cmd o_cmd
);
    import ctip_pkg::*;

    t_ctl_state r_state, n_state;
    logic       stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        stall      = i_sts.res && i_sts.pend && !i_sts.ofree;
        case (r_state)
            C_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = C_FEED;
                end
            end
            C_FEED: begin
                if (!stall) begin
                    o_cmd.feed = 1'b1;
                    if (!i_sts.more) begin
                        n_state = C_FIN;
                    end
                end
            end
            C_FIN: begin
                if (!i_sts.pend) begin
                    n_state = C_IDLE;
                end else if (i_sts.ofree) begin
                    o_cmd.fin = 1'b1;
                    n_state   = C_IDLE;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ hdl/ctip_dp.sv @@
// Datapath: parse state, header buffer, one-byte parse step, pending and output events.
// Depends on ctip_pkg and the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
module ctip_dp #(
    parameter int LINE_LIMIT = ctip_pkg::LINE_LIMIT_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [ctip_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [7:0]                        i_cfg_wdata,
    ctip_in_if.sink                           i_in,
    ctip_out_if.source                        o_out,
    input  ctip_pkg::t_ctl_cmd                i_cmd,
    output ctip_pkg::t_ctl_sts                o_sts
);
    import ctip_pkg::*;

    localparam int LW = $clog2(LINE_LIMIT);
    localparam logic [LW-1:0] LINE_MAX = LW'(LINE_LIMIT - 1);

    logic [7:0] r_sync_a, r_sync_b, r_sys_mark, r_data_mark, r_entry_mark, r_basic_mark;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_hs [8];
    logic [2:0]  r_fill, n_fill;
    logic [8:0]  r_left, n_left;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_line, n_line;
    logic [LW-1:0] r_llen, n_llen;
    logic        r_mach, n_mach;
    logic [3:0]  r_rep, n_rep;
    logic [7:0]  r_byte;

    logic        r_pend_v, r_out_v;
    t_res        r_pend, r_out, res;
    logic        r_out_last;
    logic        res_v, hs_we;
    logic [7:0]  ch, sum_ch;
    t_phase      eph;
    logic [15:0] addr_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_a     <= RST_SYNC_A;
            r_sync_b     <= RST_SYNC_B;
            r_sys_mark   <= RST_SYS_MARK;
            r_data_mark  <= RST_DATA_MARK;
            r_entry_mark <= RST_ENTRY_MARK;
            r_basic_mark <= RST_BASIC_MARK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_A:     r_sync_a     <= i_cfg_wdata;
                CFG_SYNC_B:     r_sync_b     <= i_cfg_wdata;
                CFG_SYS_MARK:   r_sys_mark   <= i_cfg_wdata;
                CFG_DATA_MARK:  r_data_mark  <= i_cfg_wdata;
                CFG_ENTRY_MARK: r_entry_mark <= i_cfg_wdata;
                CFG_BASIC_MARK: r_basic_mark <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign ch      = r_rep[3] ? r_byte : r_hs[r_rep[2:0]];
    assign sum_ch  = r_sum + ch;
    assign addr_hi = {ch, r_addr[7:0]};

    always_comb begin
        n_phase = r_phase;
        n_fill  = r_fill;
        n_left  = r_left;
        n_addr  = r_addr;
        n_sum   = r_sum;
        n_line  = r_line;
        n_llen  = r_llen;
        n_mach  = r_mach;
        n_rep   = r_rep[3] ? REPLAY_NONE : r_rep + 4'd1;
        hs_we   = 1'b0;
        res_v   = 1'b0;
        res     = '0;
        eph     = (r_phase == PH_SILENCE && ch != 8'h00) ? PH_WAIT_SYNC : r_phase;
        n_phase = eph;
        case (eph)
            PH_SILENCE: ;
            PH_WAIT_SYNC: begin
                if (ch == r_sync_a || ch == r_sync_b) begin
                    n_mach  = (ch == r_sync_a) ? 1'b0 : 1'b1;
                    n_phase = PH_HEADER;
                    n_fill  = '0;
                end else begin
                    res_v = 1'b1;
                    res.event_res  = EV_UNEXPECTED;
                    res.byte_value = ch;
                end
            end
            PH_HEADER: begin
                hs_we  = 1'b1;
                n_fill = r_fill + 3'd1;
                if (r_fill == 3'd7) begin
                    res_v = 1'b1;
                    if (r_hs[0] == r_sys_mark && ch == r_data_mark) begin
                        res.event_res = EV_SYS_HDR;
                        res.name_text = {r_hs[1], r_hs[2], r_hs[3], r_hs[4], r_hs[5], r_hs[6]};
                        n_phase = PH_SYS_COUNT;
                    end else if (r_hs[0] == r_basic_mark && r_hs[1] == r_basic_mark
                                 && r_hs[2] == r_basic_mark) begin
                        res.event_res = EV_BAS1_HDR;
                        res.name_text = {40'd0, r_hs[3]};
                        n_phase = PH_BAS_ALO;
                        n_rep   = REPLAY_BAS1;
                    end else begin
                        res.event_res = EV_BAS2_HDR;
                        res.name_text = {40'd0, r_hs[0]};
                        n_phase = PH_BAS_ALO;
                        n_rep   = REPLAY_BAS2;
                    end
                end
            end
            PH_SYS_TYPE: begin
                if (ch == r_data_mark) begin
                    n_phase = PH_SYS_COUNT;
                end else if (ch == r_entry_mark) begin
                    n_phase = PH_SYS_ELO;
                end else begin
                    res_v = 1'b1;
                    res.event_res  = EV_UNEXPECTED;
                    res.byte_value = ch;
                end
            end
            PH_SYS_COUNT: begin
                n_left  = (ch == 8'h00) ? FULL_BLOCK : {1'b0, ch};
                n_phase = PH_SYS_ALO;
            end
            PH_SYS_ALO: begin
                n_addr  = {8'h00, ch};
                n_sum   = ch;
                n_phase = PH_SYS_AHI;
            end
            PH_SYS_AHI: begin
                n_addr  = addr_hi;
                n_sum   = sum_ch;
                n_phase = PH_SYS_DATA;
                res_v = 1'b1;
                res.event_res    = EV_BLK_START;
                res.address      = addr_hi;
                res.computed_sum = sum_ch;
                res.block_length = 11'(r_left);
            end
            PH_SYS_DATA: begin
                n_sum  = sum_ch;
                n_addr = r_addr + 16'd1;
                res_v = 1'b1;
                res.event_res    = EV_DATA;
                res.address      = r_addr;
                res.byte_value   = ch;
                res.computed_sum = sum_ch;
                if (r_left != 9'd0) begin
                    n_left = r_left - 9'd1;
                end
                if (r_left <= 9'd1) begin
                    n_phase = PH_SYS_SUM;
                end
            end
            PH_SYS_SUM: begin
                res_v = 1'b1;
                res.event_res    = EV_CSUM;
                res.byte_value   = ch;
                res.computed_sum = r_sum;
                res.checksum_ok  = (ch == r_sum);
                n_phase = PH_SYS_TYPE;
            end
            PH_SYS_ELO: begin
                n_addr  = {8'h00, ch};
                n_phase = PH_SYS_EHI;
            end
            PH_SYS_EHI: begin
                n_addr  = addr_hi;
                n_phase = PH_AFTER_ENTRY;
                res_v = 1'b1;
                res.event_res = EV_ENTRY;
                res.address   = addr_hi;
            end
            PH_AFTER_ENTRY: begin
                if (ch == r_data_mark) begin
                    n_phase = PH_SYS_COUNT;
                end else if (ch == r_entry_mark) begin
                    n_phase = PH_SYS_ELO;
                end else begin
                    n_phase = PH_IGNORE;
                    res_v = 1'b1;
                    res.event_res  = EV_IGNORED;
                    res.byte_value = ch;
                end
            end
            PH_BAS_ALO: begin
                n_addr  = {8'h00, ch};
                n_phase = PH_BAS_AHI;
            end
            PH_BAS_AHI: begin
                n_addr = addr_hi;
                if (addr_hi == 16'd0) begin
                    res_v = 1'b1;
                    res.event_res = EV_PROG_END;
                    n_phase = PH_IGNORE;
                end else begin
                    n_phase = PH_BAS_LLO;
                end
            end
            PH_BAS_LLO: begin
                n_line  = {8'h00, ch};
                n_phase = PH_BAS_LHI;
            end
            PH_BAS_LHI: begin
                n_line  = {ch, r_line[7:0]};
                n_llen  = '0;
                n_phase = PH_BAS_DATA;
                res_v = 1'b1;
                res.event_res   = EV_LINE_START;
                res.address     = r_addr;
                res.line_number = {ch, r_line[7:0]};
            end
            PH_BAS_DATA: begin
                if (r_llen < LINE_MAX) begin
                    n_llen = r_llen + LW'(1);
                end
                res_v = 1'b1;
                res.address      = r_addr;
                res.line_number  = r_line;
                res.block_length = 11'(n_llen);
                if (ch == 8'h00) begin
                    res.event_res = EV_LINE_END;
                    n_phase = PH_BAS_ALO;
                end else begin
                    res.event_res  = EV_LINE_BYTE;
                    res.byte_value = ch;
                end
            end
            default: begin
                n_phase = PH_IGNORE;
                res_v = 1'b1;
                res.event_res  = EV_IGNORED;
                res.byte_value = ch;
            end
        endcase
        res.machine_kind = r_mach;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SILENCE;
            r_fill  <= '0;
            r_left  <= '0;
            r_addr  <= '0;
            r_sum   <= '0;
            r_line  <= '0;
            r_llen  <= '0;
            r_mach  <= 1'b0;
            r_rep   <= REPLAY_NONE;
        end else if (i_cmd.load) begin
            r_rep <= REPLAY_NONE;
            if (i_in.new_image) begin
                r_phase <= PH_SILENCE;
                r_fill  <= '0;
                r_left  <= '0;
                r_addr  <= '0;
                r_sum   <= '0;
                r_line  <= '0;
                r_llen  <= '0;
                r_mach  <= 1'b0;
            end
        end else if (i_cmd.feed) begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_left  <= n_left;
            r_addr  <= n_addr;
            r_sum   <= n_sum;
            r_line  <= n_line;
            r_llen  <= n_llen;
            r_mach  <= n_mach;
            r_rep   <= n_rep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_in.tape_byte;
        end
        if (i_cmd.feed && hs_we) begin
            r_hs[r_fill] <= ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cmd.feed && res_v) begin
                r_pend_v <= 1'b1;
                if (r_pend_v) begin
                    r_out_v <= 1'b1;
                end
            end
            if (i_cmd.fin) begin
                r_pend_v <= 1'b0;
                r_out_v  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.feed && res_v) begin
            r_pend <= res;
            if (r_pend_v) begin
                r_out      <= r_pend;
                r_out_last <= 1'b0;
            end
        end
        if (i_cmd.fin) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end
    end

    assign o_sts.res   = res_v;
    assign o_sts.pend  = r_pend_v;
    assign o_sts.ofree = !r_out_v || o_out.ready;
    assign o_sts.more  = !n_rep[3];

    assign o_out.valid        = r_out_v;
    assign o_out.event_res    = r_out.event_res;
    assign o_out.address      = r_out.address;
    assign o_out.line_number  = r_out.line_number;
    assign o_out.byte_value   = r_out.byte_value;
    assign o_out.computed_sum = r_out.computed_sum;
    assign o_out.block_length = r_out.block_length;
    assign o_out.name_text    = r_out.name_text;
    assign o_out.checksum_ok  = r_out.checksum_ok;
    assign o_out.machine_kind = r_out.machine_kind;
    assign o_out.last         = r_out_last;
endmodule
`default_nettype wire

@@ hdl/cassette_tape_image_parser.sv @@
// Top level of the cassette tape image parser: sequencer plus datapath.
// Depends on ctip_pkg, ctip_in_if, ctip_out_if, ctip_ctrl and ctip_dp.
//
//  channel  | dir | beat
//  i_in     | in  | tape_byte, new_image
//  o_out    | out | one parse event with last flag
//  i_cfg_*  | in  | register write, index 0..5
//
// An input beat passes through accept, parse and flush; a beat that completes a
// BASIC header also parses up to seven replayed header bytes, one per cycle.
// The single parse unit is fed one byte a cycle unless an output stall holds it.
// Output stalls hold the parser only when a second event is ready to move out.
// Reset is synchronous, active low; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module cassette_tape_image_parser #(
    parameter int LINE_LIMIT = ctip_pkg::LINE_LIMIT_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [ctip_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [7:0]                     i_cfg_wdata,
    ctip_in_if.sink                        i_in,
    ctip_out_if.source                     o_out
);
    import ctip_pkg::*;

    t_ctl_cmd cmd;
    t_ctl_sts sts;
    logic     in_ready;

    assign i_in.ready = in_ready;

    ctip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ctip_dp #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );
endmodule
`default_nettype wire
